// ----- rtl/lpdts_pkg.sv -----
// ----------------------------------------------------------------------------
// lpdts_pkg
// Types and constants shared by the time-sorting point buffer.
// ----------------------------------------------------------------------------
package lpdts_pkg;

	localparam int CoordW     = 20;
	localparam int IntensityW = 16;
	localparam int TimeW      = 32;
	localparam int RangeW     = 40;
	localparam int SqW        = 39;
	localparam int ScanW      = 20;

	localparam logic [RangeW-1:0] RANGE_RESET = 40'd40000000000;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_BEGIN  = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_POP,
		OP_BEGIN
	} chain_op_t;

	typedef struct packed {
		logic [TimeW-1:0]        tstamp;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [IntensityW-1:0]   intensity;
	} entry_t;

	typedef struct packed {
		logic [1:0] cmd;
		entry_t     ent;
	} point_t;

	typedef struct packed {
		chain_op_t op;
		entry_t    ent;
	} chain_req_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_ent;
	} cell_ctrl_t;

	typedef struct packed {
		logic   nonempty;
		logic   last_one;
		logic   overflow;
		entry_t head;
	} chain_status_t;

	typedef struct packed {
		logic                     out_valid;
		logic signed [CoordW-1:0] out_x;
		logic signed [CoordW-1:0] out_y;
		logic signed [CoordW-1:0] out_z;
		logic [IntensityW-1:0]    out_intensity;
		logic [TimeW-1:0]         out_time;
		logic                     buffer_empty;
		logic                     overflow_flag;
	} result_t;

endpackage

// ----- rtl/lpdts_point_if.sv -----
// ----------------------------------------------------------------------------
// lpdts_point_if
// Input word channel: command and one lidar point.
// ----------------------------------------------------------------------------
interface lpdts_point_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [19:0] point_x;
	logic signed [19:0] point_y;
	logic signed [19:0] point_z;
	logic [15:0]        point_intensity;
	logic [31:0]        point_time;

	modport source (
		output valid, cmd, point_x, point_y, point_z, point_intensity, point_time,
		input  ready
	);
	modport sink (
		input  valid, cmd, point_x, point_y, point_z, point_intensity, point_time,
		output ready
	);
endinterface

// ----- rtl/lpdts_result_if.sv -----
// ----------------------------------------------------------------------------
// lpdts_result_if
// Output word channel: one popped point with buffer status.
// ----------------------------------------------------------------------------
interface lpdts_result_if;
	logic               valid;
	logic               ready;
	logic               out_valid;
	logic signed [19:0] out_x;
	logic signed [19:0] out_y;
	logic signed [19:0] out_z;
	logic [15:0]        out_intensity;
	logic [31:0]        out_time;
	logic               buffer_empty;
	logic               overflow_flag;

	modport source (
		output valid, out_valid, out_x, out_y, out_z, out_intensity, out_time,
		       buffer_empty, overflow_flag,
		input  ready
	);
	modport sink (
		input  valid, out_valid, out_x, out_y, out_z, out_intensity, out_time,
		       buffer_empty, overflow_flag,
		output ready
	);
endinterface

// ----- rtl/lpdts_filter.sv -----
// ----------------------------------------------------------------------------
// lpdts_filter
// Scan counting, group decimation and range check ahead of the sort chain.
// ----------------------------------------------------------------------------
module lpdts_filter
	import lpdts_pkg::*;
#(
	parameter int GROUP_SIZE   = 64,
	parameter int GROUP_PERIOD = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  point_t            in_word,
	input  logic [RangeW-1:0] max_range_sq,
	output chain_req_t        req
);

	localparam int PosW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int GrpW = (GROUP_PERIOD > 1) ? $clog2(GROUP_PERIOD) : 1;

	logic [ScanW-1:0] scan_q;
	logic [PosW-1:0]  pos_q;
	logic [GrpW-1:0]  grp_q;

	chain_op_t op_s1;
	entry_t    ent_s1;
	logic [SqW-1:0] sqx_s1, sqy_s1, sqz_s1;
	chain_op_t op_s2;
	entry_t    ent_s2;

	logic accept;
	logic signed [2*CoordW-1:0] mx, my, mz;
	logic [SqW+1:0] dist_sq;
	chain_op_t op_in;

	assign accept = in_valid && en;
	assign mx = in_word.ent.x * in_word.ent.x;
	assign my = in_word.ent.y * in_word.ent.y;
	assign mz = in_word.ent.z * in_word.ent.z;

	always_comb begin
		case (in_word.cmd)
			CMD_INSERT: op_in = (grp_q == '0) ? OP_INSERT : OP_NONE;
			CMD_POP:    op_in = OP_POP;
			CMD_BEGIN:  op_in = OP_BEGIN;
			default:    op_in = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			pos_q  <= '0;
			grp_q  <= '0;
		end else if (accept) begin
			if (in_word.cmd == CMD_BEGIN) begin
				scan_q <= '0;
				pos_q  <= '0;
				grp_q  <= '0;
			end else if (in_word.cmd == CMD_INSERT) begin
				scan_q <= scan_q + 1'b1;
				if (scan_q == '1) begin
					pos_q <= '0;
					grp_q <= '0;
				end else if (pos_q == PosW'(GROUP_SIZE - 1)) begin
					pos_q <= '0;
					grp_q <= (grp_q == GrpW'(GROUP_PERIOD - 1)) ? '0 : grp_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			op_s2 <= OP_NONE;
		end else if (en) begin
			op_s1 <= in_valid ? op_in : OP_NONE;
			if (op_s1 == OP_INSERT && dist_sq > {1'b0, max_range_sq})
				op_s2 <= OP_NONE;
			else
				op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s1 <= in_word.ent;
			sqx_s1 <= mx[SqW-1:0];
			sqy_s1 <= my[SqW-1:0];
			sqz_s1 <= mz[SqW-1:0];
			ent_s2 <= ent_s1;
		end
	end

	assign dist_sq = (SqW+2)'(sqx_s1) + (SqW+2)'(sqy_s1) + (SqW+2)'(sqz_s1);
	assign req     = '{op: op_s2, ent: ent_s2};

endmodule

// ----- rtl/lpdts_cell.sv -----
// ----------------------------------------------------------------------------
// lpdts_cell
// One slot of the sorted chain: keep, take the new point, or shift.
// ----------------------------------------------------------------------------
module lpdts_cell
	import lpdts_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  logic       prev_le,
	input  entry_t     prev_ent,
	input  entry_t     next_ent,
	output logic       le,
	output entry_t     ent
);

	entry_t ent_q;

	assign le  = occ && (ent_q.tstamp <= ctrl.new_ent.tstamp);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !le) begin
			ent_q <= prev_le ? ctrl.new_ent : prev_ent;
		end else if (ctrl.pop) begin
			ent_q <= next_ent;
		end
	end

endmodule

// ----- rtl/lpdts_chain.sv -----
// ----------------------------------------------------------------------------
// lpdts_chain
// Row of cells kept sorted by time, with fill count and overflow flag.
// ----------------------------------------------------------------------------
module lpdts_chain
	import lpdts_pkg::*;
#(
	parameter int BUFFER_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  chain_req_t    req,
	output chain_status_t status
);

	localparam int FillW = $clog2(BUFFER_DEPTH + 1);

	logic [FillW-1:0] fill_q;
	logic             ovf_q;
	logic             full;
	cell_ctrl_t       ctrl;

	logic   le  [BUFFER_DEPTH];
	entry_t ent [BUFFER_DEPTH];

	assign full        = (fill_q == FillW'(BUFFER_DEPTH));
	assign ctrl.ins    = en && req.op == OP_INSERT && !full;
	assign ctrl.pop    = en && req.op == OP_POP && fill_q != '0;
	assign ctrl.new_ent = req.ent;

	for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
		logic   occ;
		logic   p_le;
		entry_t p_ent;
		entry_t n_ent;

		assign occ = (FillW'(i) < fill_q);
		if (i == 0) begin : g_first
			assign p_le  = 1'b1;
			assign p_ent = req.ent;
		end else begin : g_mid
			assign p_le  = le[i-1];
			assign p_ent = ent[i-1];
		end
		if (i == BUFFER_DEPTH - 1) begin : g_last
			assign n_ent = ent[i];
		end else begin : g_next
			assign n_ent = ent[i+1];
		end

		lpdts_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ),
			.prev_le  (p_le),
			.prev_ent (p_ent),
			.next_ent (n_ent),
			.le       (le[i]),
			.ent      (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (en) begin
			if (req.op == OP_BEGIN) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (req.op == OP_INSERT) begin
				if (full)
					ovf_q <= 1'b1;
				else
					fill_q <= fill_q + 1'b1;
			end else if (ctrl.pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign status.nonempty = (fill_q != '0);
	assign status.last_one = (fill_q == FillW'(1));
	assign status.overflow = ovf_q;
	assign status.head     = ent[0];

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(BUFFER_DEPTH))
		else $error("fill count beyond depth");
	a_begin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && req.op == OP_BEGIN) |=> (fill_q == '0 && !ovf_q))
		else $error("begin did not clear buffer");
	a_full_sets_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(en && req.op == OP_INSERT && full) |=> (ovf_q && $stable(fill_q)))
		else $error("insert into full buffer not flagged");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> (fill_q == $past(fill_q) - 1'b1))
		else $error("pop did not decrement fill");
`endif

endmodule

// ----- rtl/lidar_point_decimate_time_sort.sv -----
// ----------------------------------------------------------------------------
// lidar_point_decimate_time_sort
// Decimates and range-gates lidar points and keeps them sorted by time.
//
//   channel  dir  handshake       word
//   point    in   valid/ready     cmd, point_x/y/z, point_intensity, point_time
//   result   out  valid/ready     out_valid, out_x/y/z, out_intensity, out_time,
//                                 buffer_empty, overflow_flag
//   cfg      in   cfg_we          cfg_data (max_range_sq)
//
// One word is accepted per cycle while the input is not stalled; every cell of
// the chain shifts or loads in the same cycle for both inserts and pops.
// A pop word passes the square stage and the range compare stage before its
// result is loaded into the output register.
// The input stalls only when a pop reaches the chain while the output
// register still holds an untaken result.
// Reset clears fill count, scan counters and overflow; buffer contents are
// not cleared and max_range_sq returns to 200 m squared.
// ----------------------------------------------------------------------------
module lidar_point_decimate_time_sort
	import lpdts_pkg::*;
#(
	parameter int BUFFER_DEPTH = 1024,
	parameter int GROUP_SIZE   = 64,
	parameter int GROUP_PERIOD = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lpdts_point_if.sink          point,
	lpdts_result_if.source       result,
	input  logic                 cfg_we,
	input  logic [RangeW-1:0]    cfg_data
);

	logic [RangeW-1:0] max_range_q;
	logic              res_v_q;
	result_t           res_q;
	logic              en;
	point_t            in_word;
	chain_req_t        req;
	chain_status_t     status;

	assign en = !(req.op == OP_POP && res_v_q && !result.ready);

	assign in_word.cmd           = point.cmd;
	assign in_word.ent.tstamp    = point.point_time;
	assign in_word.ent.x         = point.point_x;
	assign in_word.ent.y         = point.point_y;
	assign in_word.ent.z         = point.point_z;
	assign in_word.ent.intensity = point.point_intensity;
	assign point.ready           = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_range_q <= RANGE_RESET;
		else if (cfg_we)
			max_range_q <= cfg_data;
	end

	lpdts_filter #(
		.GROUP_SIZE   (GROUP_SIZE),
		.GROUP_PERIOD (GROUP_PERIOD)
	) u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (point.valid),
		.in_word      (in_word),
		.max_range_sq (max_range_q),
		.req          (req)
	);

	lpdts_chain #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (req),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else if (en && req.op == OP_POP)
			res_v_q <= 1'b1;
		else if (result.ready)
			res_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en && req.op == OP_POP) begin
			res_q.out_valid     <= status.nonempty;
			res_q.out_x         <= status.nonempty ? status.head.x : '0;
			res_q.out_y         <= status.nonempty ? status.head.y : '0;
			res_q.out_z         <= status.nonempty ? status.head.z : '0;
			res_q.out_intensity <= status.nonempty ? status.head.intensity : '0;
			res_q.out_time      <= status.nonempty ? status.head.tstamp : '0;
			res_q.buffer_empty  <= !status.nonempty || status.last_one;
			res_q.overflow_flag <= status.overflow;
		end
	end

	assign result.valid         = res_v_q;
	assign result.out_valid     = res_q.out_valid;
	assign result.out_x         = res_q.out_x;
	assign result.out_y         = res_q.out_y;
	assign result.out_z         = res_q.out_z;
	assign result.out_intensity = res_q.out_intensity;
	assign result.out_time      = res_q.out_time;
	assign result.buffer_empty  = res_q.buffer_empty;
	assign result.overflow_flag = res_q.overflow_flag;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!point.ready |-> (res_v_q && req.op == OP_POP))
		else $error("input stalled without a waiting result");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(en && req.op == OP_POP) |=> result.valid)
		else $error("pop gave no result");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.out_valid) |-> result.buffer_empty)
		else $error("empty pop without empty status");
`endif

endmodule

// ----- tb/sv/tb_lidar_point_decimate_time_sort.sv -----
// ----------------------------------------------------------------------------
// tb_lidar_point_decimate_time_sort
// Sends insert, pop, begin and unused command words with random stalls on
// both channels. Every popped point is checked against a time-sorted copy of
// the kept points. The run covers decimation, range gating and ties in time,
// under several range limits.
// ----------------------------------------------------------------------------
module tb_lidar_point_decimate_time_sort;
	import lpdts_pkg::*;

	localparam int BufferDepth = 1024;
	localparam int GroupSize   = 64;
	localparam int GroupPeriod = 8;
	localparam int CycleLimit  = 4000000;
	localparam int DrainCycles = 8;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [RangeW-1:0] RANGE_ALL = '1;

	class time_sorted_scan;
		entry_t            kept_points[$];
		result_t           pending_pops[$];
		logic [ScanW-1:0]  scan_index;
		bit                overflow_seen;
		logic [RangeW-1:0] max_range_sq;
		int                errors;

		function new();
			scan_index    = '0;
			overflow_seen = 1'b0;
			max_range_sq  = RANGE_RESET;
			errors        = 0;
		endfunction

		function logic [63:0] square(logic signed [CoordW-1:0] c);
			longint v;
			v = longint'(c);
			return v * v;
		endfunction

		function void take_word(point_t w);
			result_t     r;
			int          pos;
			bit          keep;
			logic [63:0] d2;
			case (w.cmd)
				CMD_INSERT: begin
					keep = ((scan_index / GroupSize) % GroupPeriod) == 0;
					scan_index = scan_index + 1'b1;
					d2 = square(w.ent.x) + square(w.ent.y) + square(w.ent.z);
					if (keep && d2 <= max_range_sq) begin
						if (kept_points.size() >= BufferDepth) begin
							overflow_seen = 1'b1;
						end else begin
							pos = kept_points.size();
							while (pos > 0 && kept_points[pos-1].tstamp > w.ent.tstamp) pos--;
							kept_points.insert(pos, w.ent);
						end
					end
				end
				CMD_POP: begin
					r = '0;
					if (kept_points.size() == 0) begin
						r.buffer_empty = 1'b1;
					end else begin
						r.out_valid     = 1'b1;
						r.out_x         = kept_points[0].x;
						r.out_y         = kept_points[0].y;
						r.out_z         = kept_points[0].z;
						r.out_intensity = kept_points[0].intensity;
						r.out_time      = kept_points[0].tstamp;
						void'(kept_points.pop_front());
						r.buffer_empty  = (kept_points.size() == 0);
					end
					r.overflow_flag = overflow_seen;
					pending_pops.insert(pending_pops.size(), r);
				end
				CMD_BEGIN: begin
					kept_points.delete();
					scan_index    = '0;
					overflow_seen = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		function void check_pop(result_t got);
			result_t want;
			if (pending_pops.size() == 0) begin
				errors++;
				$display("%0t: result expected none got time %0h", $time, got.out_time);
				return;
			end
			want = pending_pops.pop_front();
			check_field("out_valid", want.out_valid, got.out_valid);
			check_field("out_x", want.out_x, got.out_x);
			check_field("out_y", want.out_y, got.out_y);
			check_field("out_z", want.out_z, got.out_z);
			check_field("out_intensity", want.out_intensity, got.out_intensity);
			check_field("out_time", want.out_time, got.out_time);
			check_field("buffer_empty", want.buffer_empty, got.buffer_empty);
			check_field("overflow_flag", want.overflow_flag, got.overflow_flag);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RangeW-1:0] cfg_data;
	bit                quiet;
	time_sorted_scan   sorted_pts;

	lpdts_point_if  point_ch();
	lpdts_result_if result_ch();

	lidar_point_decimate_time_sort #(
		.BUFFER_DEPTH(BufferDepth),
		.GROUP_SIZE(GroupSize),
		.GROUP_PERIOD(GroupPeriod)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic point_t make_point(logic [1:0] cmd, logic signed [CoordW-1:0] x,
			logic signed [CoordW-1:0] y, logic signed [CoordW-1:0] z,
			logic [IntensityW-1:0] inten, logic [TimeW-1:0] tstamp);
		point_t w;
		w.cmd           = cmd;
		w.ent.x         = x;
		w.ent.y         = y;
		w.ent.z         = z;
		w.ent.intensity = inten;
		w.ent.tstamp    = tstamp;
		return w;
	endfunction

	function automatic logic signed [CoordW-1:0] rand_coord();
		logic [31:0] wide;
		int          near;
		wide = $urandom;
		near = $urandom_range(0, 200000) - 100000;
		if ($urandom_range(0, 1) == 0) return wide[CoordW-1:0];
		return near[CoordW-1:0];
	endfunction

	function automatic logic [TimeW-1:0] rand_time();
		if ($urandom_range(0, 1) == 0) return $urandom;
		return $urandom_range(0, 15);
	endfunction

	function automatic point_t rand_insert();
		return make_point(CMD_INSERT, rand_coord(), rand_coord(), rand_coord(),
			IntensityW'($urandom), rand_time());
	endfunction

	function automatic point_t random_word();
		point_t w;
		int     pick;
		w    = rand_insert();
		pick = $urandom_range(0, 99);
		if (pick >= 96) w.cmd = CMD_UNUSED;
		else if (pick >= 92) w.cmd = CMD_BEGIN;
		else if (pick >= 55) w.cmd = CMD_POP;
		return w;
	endfunction

	function automatic point_t pop_word();
		return make_point(CMD_POP, 0, 0, 0, 0, 0);
	endfunction

	task automatic send_word(input point_t w);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point_ch.valid           <= 1'b1;
		point_ch.cmd             <= w.cmd;
		point_ch.point_x         <= w.ent.x;
		point_ch.point_y         <= w.ent.y;
		point_ch.point_z         <= w.ent.z;
		point_ch.point_intensity <= w.ent.intensity;
		point_ch.point_time      <= w.ent.tstamp;
		@(posedge clk);
		while (point_ch.ready !== 1'b1) @(posedge clk);
		sorted_pts.take_word(w);
	endtask

	task automatic hold_for_results();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (sorted_pts.pending_pops.size() != 0) @(negedge clk);
	endtask

	task automatic write_range(input logic [RangeW-1:0] v);
		hold_for_results();
		repeat (DrainCycles) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		sorted_pts.max_range_sq = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : drain_results
		int      gap;
		result_t got;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1) @(posedge clk);
			got.out_valid     = result_ch.out_valid;
			got.out_x         = result_ch.out_x;
			got.out_y         = result_ch.out_y;
			got.out_z         = result_ch.out_z;
			got.out_intensity = result_ch.out_intensity;
			got.out_time      = result_ch.out_time;
			got.buffer_empty  = result_ch.buffer_empty;
			got.overflow_flag = result_ch.overflow_flag;
			sorted_pts.check_pop(got);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [RangeW-1:0] phase_range;
		logic [63:0]       wide64;
		sorted_pts               = new();
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_data                 = '0;
		quiet                    = 1'b0;
		point_ch.valid           = 1'b0;
		point_ch.cmd             = CMD_INSERT;
		point_ch.point_x         = '0;
		point_ch.point_y         = '0;
		point_ch.point_z         = '0;
		point_ch.point_intensity = '0;
		point_ch.point_time      = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		send_word(pop_word());
		send_word(make_point(CMD_INSERT, -524288, 524287, 0, 16'hFFFF, 32'hFFFFFFFF));
		send_word(make_point(CMD_INSERT, 10, -20, 30, 1, 100));
		send_word(make_point(CMD_INSERT, -5, 5, -5, 2, 50));
		send_word(make_point(CMD_INSERT, 7, 7, 7, 3, 100));
		send_word(make_point(CMD_INSERT, 0, 0, 0, 16'hFFFF, 0));
		repeat (5) send_word(pop_word());
		send_word(make_point(CMD_UNUSED, 1, 2, 3, 4, 5));

		write_range(RANGE_ALL);
		send_word(make_point(CMD_INSERT, -524288, -524288, -524288, 0, 32'hFFFFFFFF));
		send_word(make_point(CMD_INSERT, 524287, 524287, 524287, 16'hFFFF, 32'hFFFFFFFF));
		repeat (2) send_word(pop_word());
		send_word(make_point(CMD_INSERT, 1, 1, 1, 9, 9));
		send_word(make_point(CMD_INSERT, 2, 2, 2, 8, 8));
		send_word(make_point(CMD_BEGIN, 0, 0, 0, 0, 0));
		send_word(pop_word());

		write_range('0);
		send_word(make_point(CMD_INSERT, 0, 0, 0, 16'h1234, 5));
		send_word(make_point(CMD_INSERT, 1, 0, 0, 16'h4321, 3));
		send_word(make_point(CMD_INSERT, 0, 0, -1, 16'h5555, 1));
		repeat (2) send_word(pop_word());

		for (int p = 0; p < 4; p++) begin
			wide64 = {$urandom, $urandom};
			case (p)
				0: phase_range = RANGE_RESET;
				1: phase_range = RANGE_ALL;
				2: phase_range = wide64[RangeW-1:0];
				default: phase_range = wide64[RangeW-1:0] >> $urandom_range(0, RangeW - 1);
			endcase
			write_range(phase_range);
			quiet = ($urandom_range(0, 3) == 0);
			send_word(make_point(CMD_BEGIN, 0, 0, 0, 0, 0));
			for (int n = 0; n < 70; n++) begin
				if (p == 1 && n == 35) hold_for_results();
				send_word(random_word());
			end
		end
		quiet = 1'b0;

		write_range(RANGE_ALL);
		send_word(make_point(CMD_BEGIN, 0, 0, 0, 0, 0));
		repeat (GroupSize + 16) send_word(rand_insert());
		repeat (10) send_word(pop_word());

		hold_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (sorted_pts.errors == 0 && sorted_pts.pending_pops.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
